[rtl/fpa_pkg.sv]
// Package: shared widths, defaults and operation codes of the fixed-point ALU.
`default_nettype none

package fpa_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned OP_W          = 4;
  localparam int unsigned FRAC_BITS_DEF = 8;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MIN      = 4'd4,
    OP_MAX      = 4'd5,
    OP_INC      = 4'd6,
    OP_DEC      = 4'd7,
    OP_TO_INT   = 4'd8,
    OP_FROM_INT = 4'd9
  } op_e;

endpackage

`default_nettype wire

[rtl/fpa_if.sv]
// Interfaces: request and response channels of the fixed-point ALU.
`default_nettype none

interface fpa_req_if;
  logic                                  valid;
  logic                                  ready;
  logic        [fpa_pkg::OP_W-1:0]       req_type;
  logic signed [fpa_pkg::DATA_W-1:0]     operand_a;
  logic signed [fpa_pkg::DATA_W-1:0]     operand_b;

  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [fpa_pkg::DATA_W-1:0]     result;
  logic                                  a_equals_b;
  logic                                  a_greater_b;
  logic                                  a_less_b;
  logic                                  overflow;
  logic                                  div_by_zero;

  modport source (output valid, result, a_equals_b, a_greater_b, a_less_b, overflow,
                  div_by_zero, input ready);
  modport sink   (input valid, result, a_equals_b, a_greater_b, a_less_b, overflow,
                  div_by_zero, output ready);
endinterface

`default_nettype wire

[rtl/fixed_point_alu_unit.sv]
// Top level: pipelined signed fixed-point ALU with exact, rounded multiply and divide.
`default_nettype none

// Channel  Direction  Word carries
// req_i    in         req_type, operand_a, operand_b
// rsp_o    out        result, a_equals_b, a_greater_b, a_less_b, overflow, div_by_zero
//
// Every word passes through FRAC_BITS + 35 register stages (43 at the default),
// whichever operation it asks for; the length is set by the divider, which produces
// one quotient bit per stage. One word may enter in every cycle while the pipe is not
// stalled. Reset clears only the stage valid bits. Each stage holds its word while the
// next stage is full and stalled, so empty stages close up and nothing is lost.

module fixed_point_alu_unit #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fpa_req_if.sink   req_i,
  fpa_rsp_if.source rsp_o
);

  import fpa_pkg::*;

  // Width of the scaled dividend and of the quotient.
  localparam int unsigned QW = DATA_W + FRAC_BITS;
  // Input stage, multiply stage, QW divider steps, and the output stage.
  localparam int unsigned NS = QW + 3;
  localparam int unsigned LAST = NS - 1;

  localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;
  localparam logic [63:0] POS_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] NEG_MAG = 64'h0000_0000_8000_0000;
  localparam logic signed [DATA_W-1:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SMIN = 32'sh8000_0000;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic                     neg;
    logic                     eq;
    logic                     gt;
    logic                     lt;
    logic                     ovf;
    logic                     dz;
    logic signed [DATA_W-1:0] res;
    logic [63:0]              prod;
    logic [DATA_W-1:0]        den;
    logic [QW-1:0]            num;
    logic [DATA_W-1:0]        rem;
    logic [QW-1:0]            quo;
  } stage_t;

  typedef struct packed {
    logic                     ovf;
    logic signed [DATA_W-1:0] res;
  } sat_t;

  // Signs a magnitude and saturates it to the 32-bit range.
  function automatic sat_t sat_mag(input logic neg, input logic [63:0] mag);
    sat_t s;
    s.ovf = 1'b0;
    s.res = '0;
    if (neg) begin
      if (mag > NEG_MAG) begin
        s.ovf = 1'b1;
        s.res = SMIN;
      end else begin
        s.res = DATA_W'(64'd0 - mag);
      end
    end else begin
      if (mag > POS_MAX) begin
        s.ovf = 1'b1;
        s.res = SMAX;
      end else begin
        s.res = DATA_W'(mag);
      end
    end
    return s;
  endfunction

  // Saturates a wide signed value to the 32-bit range.
  function automatic sat_t sat_wide(input logic signed [63:0] v);
    sat_t s;
    s.ovf = 1'b0;
    s.res = DATA_W'(v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      s.ovf = 1'b1;
      s.res = SMAX;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      s.ovf = 1'b1;
      s.res = SMIN;
    end
    return s;
  endfunction

  stage_t         st_q [NS];
  stage_t         st_d [NS];
  logic [NS-1:0]  vld_q;
  logic [NS-1:0]  rdy;
  logic [NS-1:0]  src_vld;

  // Stall chain: a stage may load when it is empty or its word moves on.
  always_comb begin
    rdy[LAST] = !vld_q[LAST] || rsp_o.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    src_vld[0] = req_i.valid;
    for (int k = 1; k < NS; k++) begin
      src_vld[k] = vld_q[k-1];
    end
  end

  assign req_i.ready = rdy[0];

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic signed [63:0]       wide;
      logic [DATA_W-1:0]        mag_a;
      logic [DATA_W-1:0]        mag_b;
      logic [DATA_W:0]          trial;
      logic [63:0]              mag;
      sat_t                     s;
      a     = '0;
      b     = '0;
      wide  = '0;
      mag_a = '0;
      mag_b = '0;
      trial = '0;
      mag   = '0;
      s     = '0;
      if (k == 0) begin
        // Compare flags, simple operations and operand magnitudes.
        a = req_i.operand_a;
        b = req_i.operand_b;
        mag_a = a[DATA_W-1] ? DATA_W'(0) - DATA_W'(a) : DATA_W'(a);
        mag_b = b[DATA_W-1] ? DATA_W'(0) - DATA_W'(b) : DATA_W'(b);
        st_d[k]      = '0;
        st_d[k].op   = req_i.req_type;
        st_d[k].eq   = (a == b);
        st_d[k].gt   = (a > b);
        st_d[k].lt   = (a < b);
        st_d[k].neg  = a[DATA_W-1] ^ b[DATA_W-1];
        st_d[k].den  = mag_b;
        st_d[k].num  = QW'(mag_a) << FRAC_BITS;
        st_d[k].dz   = (op_e'(req_i.req_type) == OP_DIV) && (b == '0);
        case (op_e'(req_i.req_type))
          OP_ADD:      wide = 64'(a) + 64'(b);
          OP_SUB:      wide = 64'(a) - 64'(b);
          OP_MIN:      wide = (a > b) ? 64'(b) : 64'(a);
          OP_MAX:      wide = (a > b) ? 64'(a) : 64'(b);
          OP_INC:      wide = 64'(a) + 64'sd1;
          OP_DEC:      wide = 64'(a) - 64'sd1;
          OP_TO_INT:   wide = 64'(a >>> FRAC_BITS);
          OP_FROM_INT: wide = 64'(a) <<< FRAC_BITS;
          default:     wide = '0;
        endcase
        s = sat_wide(wide);
        st_d[k].res = s.res;
        st_d[k].ovf = s.ovf;
      end else if (k == 1) begin
        // Magnitude product; divider starts with an empty remainder.
        st_d[k]      = st_q[k-1];
        mag_a        = st_q[k-1].num[QW-1 -: DATA_W];
        st_d[k].prod = 64'(mag_a) * 64'(st_q[k-1].den);
        st_d[k].rem  = '0;
        st_d[k].quo  = '0;
      end else if (k < LAST) begin
        // One restoring division step.
        st_d[k]     = st_q[k-1];
        trial       = {st_q[k-1].rem, st_q[k-1].num[QW-1]};
        st_d[k].num = st_q[k-1].num << 1;
        if (trial >= {1'b0, st_q[k-1].den}) begin
          st_d[k].rem = DATA_W'(trial - {1'b0, st_q[k-1].den});
          st_d[k].quo = {st_q[k-1].quo[QW-2:0], 1'b1};
        end else begin
          st_d[k].rem = DATA_W'(trial);
          st_d[k].quo = {st_q[k-1].quo[QW-2:0], 1'b0};
        end
      end else begin
        // Rounding half away from zero, then sign and saturation.
        st_d[k] = st_q[k-1];
        if (op_e'(st_q[k-1].op) == OP_MUL) begin
          mag = (st_q[k-1].prod + HALF) >> FRAC_BITS;
          s = sat_mag(st_q[k-1].neg, mag);
          st_d[k].res = s.res;
          st_d[k].ovf = s.ovf;
        end else if (op_e'(st_q[k-1].op) == OP_DIV) begin
          if (st_q[k-1].dz) begin
            st_d[k].res = '0;
            st_d[k].ovf = 1'b0;
          end else begin
            mag = 64'(st_q[k-1].quo) +
                  64'({st_q[k-1].rem, 1'b0} >= {1'b0, st_q[k-1].den});
            s = sat_mag(st_q[k-1].neg, mag);
            st_d[k].res = s.res;
            st_d[k].ovf = s.ovf;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= src_vld[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k] && src_vld[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign rsp_o.valid       = vld_q[LAST];
  assign rsp_o.result      = st_q[LAST].res;
  assign rsp_o.a_equals_b  = st_q[LAST].eq;
  assign rsp_o.a_greater_b = st_q[LAST].gt;
  assign rsp_o.a_less_b    = st_q[LAST].lt;
  assign rsp_o.overflow    = st_q[LAST].ovf;
  assign rsp_o.div_by_zero = st_q[LAST].dz;

endmodule

`default_nettype wire
